/* design/audio_flanger_top_defines.svh */
// ----------------------------------------------------------------------------
// Flanger assertion macros
// Shared property wrappers for the checker that watches the flanger ports.
// ----------------------------------------------------------------------------
`ifndef AUDIO_FLANGER_TOP_DEFINES_SVH
`define AUDIO_FLANGER_TOP_DEFINES_SVH

// Same-cycle implication, clocked by aclk and disabled while reset is low.
`define AFL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked by aclk and disabled while reset is low.
`define AFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/afl_pkg.sv */
// ----------------------------------------------------------------------------
// Flanger package
// Sizes, register indexes, multiply-add request type and the quarter-wave
// sine table shared by the flanger modules.
// ----------------------------------------------------------------------------
package afl_pkg;

    // Audio and delay line sizes.
    localparam int SAMPLE_W        = 16;
    localparam int LINE_LENGTH     = 2048;
    localparam int PTR_W           = $clog2(LINE_LENGTH);
    localparam int FRAC_W          = 8;
    localparam int POS_W           = PTR_W + FRAC_W;

    // Configuration registers.
    localparam int CFG_ADDR_W      = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int STEP_W          = 32;
    localparam int DEPTH_W         = 19;
    localparam int MIX_W           = 17;
    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEPTH      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WET_MIX    = 2'd2;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 32'd48696;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 19'd56448;
    localparam logic [MIX_W-1:0]   MIX_RESET   = 17'd32768;
    localparam logic [MIX_W-1:0]   MIX_UNITY   = 17'd65536;

    // Sine LFO.
    localparam int PHASE_W         = 32;
    localparam int SINE_TABLE_SIZE = 256;
    localparam int SINE_IDX_W      = $clog2(SINE_TABLE_SIZE);
    localparam int QUARTER         = SINE_TABLE_SIZE / 4;
    localparam int QK_W            = SINE_IDX_W - 2;
    localparam int QIDX_W          = $clog2(QUARTER + 1);
    localparam int QSINE_W         = 15;

    // Shared multiply-add unit.
    localparam int MAC_A_W         = 20;
    localparam int MAC_B_W         = 18;
    localparam int MAC_W           = 38;

    typedef struct packed {
        logic                      en;
        logic signed [MAC_A_W-1:0] op_a;
        logic signed [MAC_B_W-1:0] op_b;
        logic signed [MAC_W-1:0]   addend;
    } mac_req_t;

    typedef logic [QSINE_W-1:0] qsine_tab_t [0:QUARTER];

    // sin(x) for x in [0, pi/2] given in Q30, Taylor series, result Q15 rounded.
    function automatic logic [QSINE_W-1:0] sine_q15(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        term = x;
        sum  = x;
        for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        r = (sum + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[QSINE_W-1:0];
    endfunction

    // Quarter-wave table, entry k holds sin(k * pi/2 / QUARTER) in Q15.
    function automatic qsine_tab_t build_qsine();
        qsine_tab_t tab;
        for (int k = 0; k <= QUARTER; k++) begin
            tab[k] = sine_q15((64'd1686629713 * 64'(k)) / QUARTER);
        end
        return tab;
    endfunction

    localparam qsine_tab_t QSINE = build_qsine();

endpackage

/* design/audio_flanger_top.sv */
// ----------------------------------------------------------------------------
// Audio flanger
// Sine-LFO flanger: delay line with linearly interpolated read and
// dry/wet mix, computed by one shared multiply-add unit under a sequencer.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Contents
//  s_       | in        | tdata[15:0] sample_in, signed Q1.15
//  m_       | out       | tdata[15:0] sample_out, signed Q1.15, saturated
//  cfg_     | in        | write only: 0 phase step, 1 depth, 2 wet mix
//
//  A word is not taken until the sequencer is done with the previous one:
//  the multiply-add unit runs three times (delay, interpolation, mix) and
//  the single read port of the delay RAM fetches the two neighbors in turn.
//  A new word is taken while the previous result still waits on m_tready;
//  the sequencer holds in its last step until the output register is free.
//  Reset is synchronous and does not sweep the delay RAM: entries that the
//  write pointer has not reached since reset read as zero.
// ----------------------------------------------------------------------------
module audio_flanger_top
    import afl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,    // [15:0] sample_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,    // [15:0] sample_out
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Sequencer steps.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DLY  = 3'd1;
    localparam logic [2:0] ST_RDA  = 3'd2;
    localparam logic [2:0] ST_RDB  = 3'd3;
    localparam logic [2:0] ST_INT  = 3'd4;
    localparam logic [2:0] ST_MIX  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam int RES_W = MAC_W - 16;
    localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(32767);
    localparam logic signed [RES_W-1:0] RES_MIN = -RES_W'(32768);

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [STEP_W-1:0]           step_reg;
    logic [DEPTH_W-1:0]          depth_reg;
    logic [MIX_W-1:0]            mix_reg;
    logic [PTR_W-1:0]            wp_reg;
    logic                        full_reg;
    logic signed [SAMPLE_W-1:0]  dry_reg;
    logic signed [SAMPLE_W-1:0]  lfo_reg;
    logic [PTR_W-1:0]            idx_reg;
    logic [FRAC_W-1:0]           frac_reg;
    logic signed [SAMPLE_W-1:0]  a_reg;
    logic                        m_tvalid_reg;
    logic [SAMPLE_W-1:0]         m_tdata_reg;

    logic                        accept;
    logic                        out_free;
    logic signed [SAMPLE_W-1:0]  lfo_val;
    mac_req_t                    mac_req;
    logic signed [MAC_W-1:0]     mac_acc;
    logic [SAMPLE_W-1:0]         ram_rdata;
    logic [PTR_W-1:0]            ram_raddr;
    logic [PTR_W-1:0]            nxt_idx;
    logic [POS_W-1:0]            dly;
    logic [POS_W-1:0]            pos;
    logic signed [SAMPLE_W-1:0]  rd_val;
    logic                        a_valid;
    logic                        b_valid;
    logic signed [SAMPLE_W:0]    diff;
    logic signed [SAMPLE_W-1:0]  wet;
    logic [MIX_W-1:0]            mix_sat;
    logic signed [RES_W-1:0]     res;
    logic [SAMPLE_W-1:0]         res_sat;
    logic [SAMPLE_W:0]           lfo_ofs;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // Configuration register writes; index three is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= STEP_RESET;
            depth_reg <= DEPTH_RESET;
            mix_reg   <= MIX_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_PHASE_STEP: step_reg  <= cfg_wdata[STEP_W-1:0];
                CFG_DEPTH:      depth_reg <= cfg_wdata[DEPTH_W-1:0];
                CFG_WET_MIX:    mix_reg   <= cfg_wdata[MIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // LFO: sampled and advanced when a word is taken.
    afl_lfo u_lfo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step_reg),
        .advance (accept),
        .lfo_val (lfo_val)
    );

    // Delay line: written on acceptance, read twice per word.
    afl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_LENGTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (wp_reg),
        .wr_data (s_tdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    afl_mac u_mac (
        .aclk (aclk),
        .req  (mac_req),
        .acc  (mac_acc)
    );

    // Read position: write pointer minus the delay, modulo the line.
    assign dly     = mac_acc[16 +: POS_W];
    assign pos     = {wp_reg, FRAC_W'(0)} - dly;
    assign nxt_idx = idx_reg + PTR_W'(1);
    assign ram_raddr = (state_reg == ST_RDA) ? pos[POS_W-1 -: PTR_W] : nxt_idx;

    // Entries the write pointer has not reached since reset read as zero.
    assign a_valid = full_reg || (idx_reg <= wp_reg);
    assign b_valid = full_reg || (nxt_idx <= wp_reg);
    assign rd_val  = $signed(ram_rdata);

    // The LFO value captured with the word, before the phase advanced.
    assign lfo_ofs = (SAMPLE_W + 1)'(32768) + (SAMPLE_W + 1)'(lfo_reg);
    assign wet     = mac_acc[FRAC_W +: SAMPLE_W];
    assign mix_sat = (mix_reg > MIX_UNITY) ? MIX_UNITY : mix_reg;

    // Difference term for interpolation (b - a) or mix (wet - dry).
    always_comb begin
        if (state_reg == ST_INT) begin
            diff = (b_valid ? (SAMPLE_W + 1)'(rd_val) : '0) - (SAMPLE_W + 1)'(a_reg);
        end else begin
            diff = (SAMPLE_W + 1)'(wet) - (SAMPLE_W + 1)'(dry_reg);
        end
    end

    // Multiply-add requests issued by the sequencer.
    always_comb begin
        mac_req        = '0;
        mac_req.op_a   = MAC_A_W'(diff);
        mac_req.op_b   = $signed({{(MAC_B_W - MIX_W){1'b0}}, mix_sat});
        mac_req.addend = (MAC_W'(dry_reg) <<< 16) + MAC_W'(32768);
        unique case (state_reg)
            ST_DLY: begin
                mac_req.en     = 1'b1;
                mac_req.op_a   = $signed({{(MAC_A_W - DEPTH_W){1'b0}}, depth_reg});
                mac_req.op_b   = $signed({{(MAC_B_W - SAMPLE_W){1'b0}},
                                          lfo_ofs[SAMPLE_W-1:0]});
                mac_req.addend = '0;
            end
            ST_INT: begin
                mac_req.en     = 1'b1;
                mac_req.op_b   = $signed({{(MAC_B_W - FRAC_W){1'b0}}, frac_reg});
                mac_req.addend = (MAC_W'(a_reg) <<< FRAC_W) + MAC_W'(128);
            end
            ST_MIX: begin
                mac_req.en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Round and saturate the mixed sample.
    assign res = mac_acc[MAC_W-1:16];
    always_comb begin
        if (res > RES_MAX) begin
            res_sat = SAMPLE_W'(RES_MAX);
        end else if (res < RES_MIN) begin
            res_sat = SAMPLE_W'(RES_MIN);
        end else begin
            res_sat = res[SAMPLE_W-1:0];
        end
    end

    // Sequencer next step.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_DLY;
            ST_DLY:  state_next = ST_RDA;
            ST_RDA:  state_next = ST_RDB;
            ST_RDB:  state_next = ST_INT;
            ST_INT:  state_next = ST_MIX;
            ST_MIX:  state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            full_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
                wp_reg       <= wp_reg + PTR_W'(1);
                if (wp_reg == PTR_W'(LINE_LENGTH - 1)) begin
                    full_reg <= 1'b1;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            dry_reg <= $signed(s_tdata);
            lfo_reg <= lfo_val;
        end
        if (state_reg == ST_RDA) begin
            idx_reg  <= pos[POS_W-1 -: PTR_W];
            frac_reg <= pos[FRAC_W-1:0];
        end
        if (state_reg == ST_RDB) begin
            a_reg <= a_valid ? rd_val : '0;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= res_sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* design/afl_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module afl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/afl_mac.sv */
// ----------------------------------------------------------------------------
// Flanger multiply-add unit
// Signed multiply with an added term, result registered. Shared by the
// delay, interpolation and mix steps.
// ----------------------------------------------------------------------------
module afl_mac
    import afl_pkg::*;
(
    input  logic                    aclk,
    input  mac_req_t                req,
    output logic signed [MAC_W-1:0] acc
);

    logic signed [MAC_W-1:0] acc_reg;
    logic signed [MAC_W-1:0] acc_next;

    // One product plus the addend per issued request.
    assign acc_next = req.addend + MAC_W'(req.op_a) * MAC_W'(req.op_b);

    always_ff @(posedge aclk) begin
        if (req.en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

/* design/afl_lfo.sv */
// ----------------------------------------------------------------------------
// Flanger sine LFO
// 32-bit phase accumulator and quarter-wave table lookup. The value shown
// belongs to the current phase; the phase advances when a word is taken.
// ----------------------------------------------------------------------------
module afl_lfo
    import afl_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [STEP_W-1:0]          step,
    input  logic                       advance,
    output logic signed [SAMPLE_W-1:0] lfo_val
);

    logic [PHASE_W-1:0]    phase_reg;
    logic [PHASE_W-1:0]    phase_next;
    logic [SINE_IDX_W-1:0] tab_idx;
    logic [1:0]            quad;
    logic [QK_W-1:0]       k;
    logic [QIDX_W-1:0]     q_idx;
    logic [QSINE_W-1:0]    mag;

    // Phase accumulator, wraps modulo 2^32.
    assign phase_next = advance ? phase_reg + step : phase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // Fold the full-cycle index onto the stored quarter wave.
    assign tab_idx = phase_reg[PHASE_W-1 -: SINE_IDX_W];
    assign quad    = tab_idx[SINE_IDX_W-1 -: 2];
    assign k       = tab_idx[QK_W-1:0];
    assign q_idx   = quad[0] ? QIDX_W'(QUARTER) - QIDX_W'(k) : QIDX_W'(k);
    assign mag     = QSINE[q_idx];

    // Second half of the cycle is negative.
    assign lfo_val = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

/* design/afl_checker.sv */
// ----------------------------------------------------------------------------
// Flanger port checker
// Watches the top-level ports for output holding and sequencer occupancy.
// ----------------------------------------------------------------------------
`include "audio_flanger_top_defines.svh"

module afl_checker
    import afl_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [SAMPLE_W-1:0] m_tdata
);

    // A stalled result keeps its word.
    `AFL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output word changed")

    // A taken word keeps the block busy on the next cycle.
    `AFL_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input ready right after a word was taken")

    // A new result only appears as the sequencer finishes its busy phase.
    `AFL_ASSERT_NOW(a_result_from_busy, $rose(m_tvalid), $past(!s_tready), "result appeared while the block was idle")

endmodule

bind audio_flanger_top afl_checker u_afl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
